>>> sv/bpfa_pkg.sv
`timescale 1ns / 1ps
package bpfa_pkg;
  localparam int NUM_FRAMES_DEF    = 4096;
  localparam int PAGE_SHIFT_DEF    = 12;
  localparam int COUNTER_WIDTH_DEF = 32;

  localparam logic [2:0] OP_ALLOC_ONE   = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN   = 3'd1;
  localparam logic [2:0] OP_ALLOC_ABOVE = 3'd2;
  localparam logic [2:0] OP_FREE_RUN    = 3'd3;
  localparam logic [2:0] OP_RESERVE_RUN = 3'd4;

  localparam logic [0:0] REG_TOTAL = 1'd0;
  localparam logic [0:0] REG_LIMIT = 1'd1;

  localparam logic [7:0] GROUP_FULL = 8'hFF;
endpackage

>>> sv/bpfa_map.sv
`timescale 1ns / 1ps
// Bit-addressed frame map: one used bit and one reserved bit per frame.
// Single read/write port; read data is registered.
module bpfa_map #(
  parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(NUM_FRAMES)-1:0] addr,
  input  logic                          we_used,
  input  logic                          used_wdata,
  input  logic                          we_rsv,
  input  logic                          rsv_wdata,
  output logic                          used_q,
  output logic                          rsv_q
);
  logic used_mem [NUM_FRAMES];
  logic rsv_mem  [NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (we_used) used_mem[addr] <= used_wdata;
    if (we_rsv) rsv_mem[addr] <= rsv_wdata;
    used_q <= used_mem[addr];
    rsv_q  <= rsv_mem[addr];
  end
endmodule

>>> sv/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
// Bitmap page-frame allocator. Hold start high with a command; it is taken at
// the edge where busy is low. One result appears for a single cycle with done
// high and cannot be held off: the receiver cannot stall. The map lives in a
// one-bit-per-cycle memory with registered reads, so each scanning operation
// walks frames one at a time through a shared index/compare unit. Alloc one
// first reduces the next-fit index below the ceiling (one subtraction at a
// time, none when it is already below), then visits frames one by one and
// skips each fully used aligned group of eight. Alloc run and alloc above scan
// frames one by one, and alloc run then marks each frame of the run. Free
// checks every frame of the run, then clears them in a second pass; reserve
// marks each frame in turn. Finishing also counts allocatable frames when the
// ceiling is under total_frames. done is high with busy already low, so the
// next command can be taken at that edge. After reset or a write to
// total_frames, a clearing pass over all NUM_FRAMES frames runs with busy high.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int NUM_FRAMES    = NUM_FRAMES_DEF,
  parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [47:0] address,
  input  logic [15:0] frame_count,
  output logic        done,
  output logic        ok,
  output logic [23:0] result_address,
  output logic [12:0] free_frames,
  output logic [12:0] used_frames,
  output logic [12:0] allocatable_frames,
  output logic [31:0] rejected_free_total,
  output logic [31:0] failed_alloc_total,
  output logic [12:0] longest_scan
);
  localparam int IW = $clog2(NUM_FRAMES);
  localparam int FW = IW + 1;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
                         S_EV = 4'd3, S_FCHK = 4'd4, S_FCLR = 4'd5,
                         S_RSV = 4'd6, S_MARK = 4'd7, S_CNT = 4'd8,
                         S_CNTE = 4'd9, S_OUT = 4'd10, S_GRP = 4'd11,
                         S_MOD = 4'd12;

  logic [3:0]  state;
  logic [2:0]  op;
  logic [47:0] addr_r;
  logic [15:0] cnt_r;
  logic [FW-1:0] total, limit_reg, free_count, idx, i_ctr, run, run_start, nfi, acnt;
  logic [FW-1:0] steps, max_steps, frame;
  logic [2:0]  gbit;
  logic [7:0]  gbits;
  logic        res_ok;
  logic [COUNTER_WIDTH-1:0] rej, afail;

  logic [IW-1:0] m_addr;
  logic m_we_u, m_wu, m_we_r, m_wr, used_q, rsv_q;

  bpfa_map #(.NUM_FRAMES(NUM_FRAMES)) u_map (
    .clk, .addr(m_addr), .we_used(m_we_u), .used_wdata(m_wu),
    .we_rsv(m_we_r), .rsv_wdata(m_wr), .used_q, .rsv_q
  );

  logic [FW-1:0] lim;
  always_comb begin
    lim = limit_reg;
    if (lim == '0) lim = FW'(1);
    if (lim > total) lim = total;
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LIMIT) prdata[12:0] = 13'(limit_reg);
    else prdata[12:0] = 13'(total);
  end

  logic [12:0] wv;
  logic [FW-1:0] wv_cl;
  always_comb begin
    wv = pwdata[12:0];
    if (wv == '0) wv = 13'd1;
    if ({1'b0, wv} > 14'(NUM_FRAMES)) wv = 13'(NUM_FRAMES);
    wv_cl = FW'(wv);
  end

  // free/reserve start frame and validity
  logic [47:0] sf48;
  logic aligned, rng_ok;
  assign sf48 = address >> PAGE_SHIFT;
  assign aligned = (address[PAGE_SHIFT-1:0] == '0);
  assign rng_ok = (sf48 < 48'(total)) && (48'(frame_count) <= 48'(total) - sf48);
  logic [47:0] above48;
  assign above48 = (address >> PAGE_SHIFT) + 48'(address[PAGE_SHIFT-1:0] != '0);

  logic [COUNTER_WIDTH-1:0] cmax;
  assign cmax = '1;

  assign busy = (state != S_IDLE);

  // next scan position for alloc one, wrapping at the ceiling
  logic [FW-1:0] nidx;
  assign nidx = (idx + FW'(1) == lim) ? '0 : idx + FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; total <= FW'(NUM_FRAMES); limit_reg <= FW'(NUM_FRAMES);
      free_count <= FW'(NUM_FRAMES - 1); nfi <= '0; rej <= '0; afail <= '0;
      max_steps <= '0; idx <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr && paddr[2] == REG_LIMIT) limit_reg <= FW'(pwdata[12:0]);
      if (cfg_wr && paddr[2] == REG_TOTAL) begin
        total <= wv_cl; free_count <= wv_cl - FW'(1); nfi <= '0;
        idx <= '0; state <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            idx <= idx + FW'(1);
            if (idx == FW'(NUM_FRAMES - 1)) state <= S_IDLE;
          end
          S_IDLE: if (start) begin
            // a run of one frame is served as alloc one
            op <= (operation == OP_ALLOC_RUN && frame_count == 16'd1) ?
                  OP_ALLOC_ONE : operation;
            addr_r <= address; cnt_r <= frame_count;
            steps <= '0; run <= '0; res_ok <= 1'b0; frame <= '0;
            unique case (operation)
              OP_ALLOC_ONE: begin
                idx <= nfi; i_ctr <= '0; gbit <= '0;
                state <= (nfi >= lim) ? S_MOD : S_GRP;
              end
              OP_ALLOC_RUN: begin
                if (frame_count == '0 || 17'(frame_count) > 17'(lim)) state <= S_MARK;
                else if (frame_count == 16'd1) begin
                  idx <= nfi; i_ctr <= '0; gbit <= '0;
                  state <= (nfi >= lim) ? S_MOD : S_GRP;
                end else begin
                  idx <= '0; i_ctr <= '0; state <= S_RD;
                end
              end
              OP_ALLOC_ABOVE: begin
                if (above48 >= 48'(lim)) state <= S_MARK;
                else begin idx <= FW'(above48); state <= S_RD; end
              end
              OP_FREE_RUN: begin
                if (address == '0 || !aligned || frame_count == '0 || !rng_ok) begin
                  if (rej != cmax) rej <= rej + COUNTER_WIDTH'(1);
                  state <= S_CNT;
                end else begin
                  idx <= FW'(sf48); i_ctr <= '0; state <= S_FCHK;
                end
              end
              OP_RESERVE_RUN: begin
                if (!aligned || frame_count == '0 || !rng_ok) state <= S_CNT;
                else begin idx <= FW'(sf48); i_ctr <= '0; state <= S_RD; end
              end
              default: state <= S_CNT;
            endcase
          end
          // next-fit index may sit above a lowered ceiling
          S_MOD: begin
            idx <= idx - lim;
            if (idx - lim < lim) state <= S_GRP;
          end
          // alloc one: gather the 8 used bits of a group when aligned
          S_GRP: begin
            if (idx[2:0] == 3'd0 && lim - idx >= FW'(8) && lim - i_ctr >= FW'(8)) begin
              if (gbit != 3'd0) gbits[gbit - 3'd1] <= used_q;
              if (gbit == 3'd0) gbit <= 3'd1;
              else if (gbit == 3'd7) begin gbit <= '0; state <= S_EV; end
              else gbit <= gbit + 3'd1;
              if (gbit == 3'd7) gbits[7] <= 1'b0; // last bit via S_EV read
            end else state <= S_RD;
          end
          S_RD: state <= S_EV;
          S_EV: begin
            unique case (op)
              OP_ALLOC_ONE: begin
                logic grp;
                grp = (idx[2:0] == 3'd0 && lim - idx >= FW'(8) && lim - i_ctr >= FW'(8));
                steps <= steps + FW'(1);
                if (grp && {used_q, gbits[6:0]} == GROUP_FULL) begin
                  if (i_ctr + FW'(8) >= lim) begin res_ok <= 1'b0; state <= S_MARK; end
                  else begin
                    i_ctr <= i_ctr + FW'(8);
                    idx <= (idx + FW'(8) >= lim) ? idx + FW'(8) - lim : idx + FW'(8);
                    state <= S_GRP;
                  end
                end else if (grp && gbits[0] == 1'b0) begin
                  res_ok <= 1'b1; frame <= idx; state <= S_MARK;
                end else if (!grp && !used_q) begin
                  res_ok <= 1'b1; frame <= idx; state <= S_MARK;
                end else if (i_ctr + FW'(1) >= lim) begin
                  res_ok <= 1'b0; state <= S_MARK;
                end else begin
                  i_ctr <= i_ctr + FW'(1); idx <= nidx; state <= S_GRP;
                end
              end
              OP_ALLOC_RUN: begin
                steps <= steps + FW'(1);
                if (!used_q) begin
                  if (run == '0) run_start <= idx;
                  run <= run + FW'(1);
                  if (run + FW'(1) == FW'(cnt_r)) begin
                    res_ok <= 1'b1; frame <= (run == '0) ? idx : run_start;
                    idx <= (run == '0) ? idx : run_start; i_ctr <= '0; state <= S_MARK;
                  end else if (idx + FW'(1) >= lim) state <= S_MARK;
                  else begin idx <= idx + FW'(1); state <= S_RD; end
                end else begin
                  run <= '0;
                  if (idx + FW'(1) >= lim) state <= S_MARK;
                  else begin idx <= idx + FW'(1); state <= S_RD; end
                end
              end
              OP_ALLOC_ABOVE: begin
                steps <= steps + FW'(1);
                if (!used_q) begin res_ok <= 1'b1; frame <= idx; state <= S_MARK; end
                else if (idx + FW'(1) >= lim) state <= S_MARK;
                else begin idx <= idx + FW'(1); state <= S_RD; end
              end
              default: begin // reserve
                if (!used_q) free_count <= free_count - FW'(1);
                if (i_ctr + FW'(1) == FW'(cnt_r)) begin res_ok <= 1'b1; state <= S_CNT; end
                else begin i_ctr <= i_ctr + FW'(1); idx <= idx + FW'(1); state <= S_RD; end
              end
            endcase
          end
          // finish an allocation: write used bits, stats
          S_MARK: begin
            if (res_ok && op == OP_ALLOC_RUN && i_ctr + FW'(1) < FW'(cnt_r)) begin
              i_ctr <= i_ctr + FW'(1); idx <= idx + FW'(1);
            end else begin
              if (steps > max_steps) max_steps <= steps;
              if (res_ok) begin
                if (op == OP_ALLOC_RUN) free_count <= free_count - FW'(cnt_r);
                else begin
                  free_count <= free_count - FW'(1);
                  if (op == OP_ALLOC_ONE) nfi <= (frame + FW'(1) == lim) ? '0 : frame + FW'(1);
                end
              end else if (afail != cmax) afail <= afail + COUNTER_WIDTH'(1);
              state <= S_CNT;
            end
          end
          S_FCHK: state <= S_FCLR;
          S_FCLR: begin
            if (rsv_q || !used_q) begin
              if (rej != cmax) rej <= rej + COUNTER_WIDTH'(1);
              state <= S_CNT;
            end else if (i_ctr + FW'(1) == FW'(cnt_r)) begin
              idx <= FW'(addr_r >> PAGE_SHIFT); i_ctr <= '0; state <= S_RSV;
            end else begin
              i_ctr <= i_ctr + FW'(1); idx <= idx + FW'(1); state <= S_FCHK;
            end
          end
          S_RSV: begin // clear pass of a valid free
            if (i_ctr + FW'(1) == FW'(cnt_r)) begin
              res_ok <= 1'b1; free_count <= free_count + FW'(cnt_r);
              if (FW'(addr_r >> PAGE_SHIFT) < nfi) nfi <= FW'(addr_r >> PAGE_SHIFT);
              state <= S_CNT;
            end else begin i_ctr <= i_ctr + FW'(1); idx <= idx + FW'(1); end
          end
          S_CNT: begin
            acnt <= '0; idx <= '0;
            if (lim == total) state <= S_OUT; else state <= S_CNTE;
          end
          S_CNTE: begin // idx leads the registered read by one
            if (idx != '0 && !used_q) acnt <= acnt + FW'(1);
            if (idx == lim) state <= S_OUT;
            else idx <= idx + FW'(1);
          end
          S_OUT: begin
            done <= 1'b1; ok <= res_ok;
            result_address <= ((op == OP_ALLOC_ONE || op == OP_ALLOC_RUN ||
                                op == OP_ALLOC_ABOVE) && res_ok) ?
                              24'(48'(frame) << PAGE_SHIFT) : '0;
            free_frames <= 13'(free_count);
            used_frames <= 13'(total - free_count);
            allocatable_frames <= (lim == total) ? 13'(free_count) : 13'(acnt);
            rejected_free_total <= 32'(rej);
            failed_alloc_total <= 32'(afail);
            longest_scan <= 13'(max_steps);
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // memory port control; group gather reads idx+gbit
  always_comb begin
    m_addr = IW'(idx); m_we_u = 1'b0; m_wu = 1'b0; m_we_r = 1'b0; m_wr = 1'b0;
    unique case (state)
      S_CLEAR: begin
        m_we_u = 1'b1; m_we_r = 1'b1;
        m_wu = (idx == '0); m_wr = (idx == '0);
      end
      S_GRP: m_addr = IW'(idx + FW'(gbit));
      S_EV: if (op == OP_RESERVE_RUN) begin
        m_we_u = 1'b1; m_wu = 1'b1; m_we_r = 1'b1; m_wr = 1'b1;
      end
      S_MARK: if (res_ok) begin
        m_addr = (op == OP_ALLOC_RUN) ? IW'(idx) : IW'(frame);
        m_we_u = 1'b1; m_wu = 1'b1;
      end
      S_RSV: begin m_we_u = 1'b1; m_wu = 1'b0; end
      default: ;
    endcase
  end
endmodule

>>> sv/bpfa_checker.sv
`timescale 1ns / 1ps
module bpfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic [23:0] result_address,
  input logic [12:0] free_frames,
  input logic [12:0] used_frames
);
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after a command transfer");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> result_address == '0)
    else $error("failed result carries address");
  a_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (14'(free_frames) + 14'(used_frames)) <= 14'd4096)
    else $error("free plus used too large");
endmodule

bind bitmap_page_frame_allocator bpfa_checker u_chk (
  .clk, .rst, .start, .busy, .done, .ok, .result_address, .free_frames, .used_frames
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bpfa_pkg::*;

  localparam int NF = 4096;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic        ok;
    logic [23:0] raddr;
    logic [12:0] nfree;
    logic [12:0] nused;
    logic [12:0] nalloc;
    logic [31:0] rejects;
    logic [31:0] fails;
    logic [12:0] scan;
  } frame_status_t;

  typedef struct {
    logic [2:0]  op;
    logic [47:0] addr;
    logic [15:0] cnt;
    bit          typed;
    logic        ok;
    logic [23:0] raddr;
  } cmd_row_t;

  typedef struct {
    int unsigned frame;
    int unsigned cnt;
  } grant_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic [2:0] operation = '0;
  logic [47:0] address = '0;
  logic [15:0] frame_count = '0;
  logic done, ok;
  logic [23:0] result_address;
  logic [12:0] free_frames, used_frames, allocatable_frames, longest_scan;
  logic [31:0] rejected_free_total, failed_alloc_total;

  bitmap_page_frame_allocator u_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // allocator shadow state
  bit used_m[NF];
  bit rsv_m[NF];
  int unsigned tot_frames, lim_reg, free_cnt, next_fit, max_scan;
  longint unsigned rej_cnt, fail_cnt;

  frame_status_t pending_q[$];
  grant_t grants[$];
  int errors = 0;
  int wdog = 0;

  function automatic int unsigned ceiling();
    int unsigned l;
    l = lim_reg;
    if (l < 1) l = 1;
    if (l > tot_frames) l = tot_frames;
    return l;
  endfunction

  function automatic void clear_maps();
    foreach (used_m[i]) begin
      used_m[i] = 0;
      rsv_m[i] = 0;
    end
    used_m[0] = 1;
    rsv_m[0] = 1;
    free_cnt = tot_frames - 1;
    next_fit = 0;
    grants.delete();
  endfunction

  function automatic void note_scan(int unsigned s);
    if (s > max_scan) max_scan = s;
  endfunction

  function automatic bit take_one(output int unsigned fr);
    int unsigned lim, steps, idx;
    bit full;
    lim = ceiling();
    steps = 0;
    fr = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      idx = (next_fit + i) % lim;
      steps++;
      if (idx % 8 == 0 && lim - idx >= 8 && lim - i >= 8) begin
        full = 1;
        for (int k = 0; k < 8; k++) full &= used_m[idx + k];
        if (full) begin
          i += 7;
          continue;
        end
      end
      if (!used_m[idx]) begin
        used_m[idx] = 1;
        free_cnt--;
        next_fit = (idx + 1) % lim;
        note_scan(steps);
        fr = idx;
        return 1;
      end
    end
    note_scan(steps);
    return 0;
  endfunction

  function automatic bit take_run(int unsigned cnt, output int unsigned fr);
    int unsigned lim, run, first, steps;
    lim = ceiling();
    run = 0;
    first = 0;
    steps = 0;
    fr = 0;
    if (cnt == 0 || cnt > lim) return 0;
    if (cnt == 1) return take_one(fr);
    for (int unsigned i = 0; i < lim; i++) begin
      steps++;
      if (!used_m[i]) begin
        if (run == 0) first = i;
        run++;
        if (run == cnt) begin
          for (int unsigned j = 0; j < cnt; j++) used_m[first + j] = 1;
          free_cnt -= cnt;
          note_scan(steps);
          fr = first;
          return 1;
        end
      end else begin
        run = 0;
      end
    end
    note_scan(steps);
    return 0;
  endfunction

  function automatic bit take_above(logic [47:0] addr, output int unsigned fr);
    longint unsigned first;
    int unsigned lim, steps;
    lim = ceiling();
    steps = 0;
    fr = 0;
    first = (longint'(addr) + 4095) >> 12;
    for (longint unsigned i = first; i < lim; i++) begin
      steps++;
      if (!used_m[i]) begin
        used_m[i] = 1;
        free_cnt--;
        note_scan(steps);
        fr = 32'(i);
        return 1;
      end
    end
    note_scan(steps);
    return 0;
  endfunction

  function automatic bit give_back(logic [47:0] addr, int unsigned cnt);
    longint unsigned s;
    s = addr >> 12;
    if (addr == 0 || addr[11:0] != 0 || cnt == 0 || s >= tot_frames || cnt > tot_frames - s)
      return 0;
    for (int unsigned i = 0; i < cnt; i++)
      if (rsv_m[s + i] || !used_m[s + i]) return 0;
    for (int unsigned i = 0; i < cnt; i++) used_m[s + i] = 0;
    free_cnt += cnt;
    if (s < next_fit) next_fit = s;
    return 1;
  endfunction

  function automatic bit pin_run(logic [47:0] addr, int unsigned cnt);
    longint unsigned s;
    s = addr >> 12;
    if (addr[11:0] != 0 || cnt == 0 || s >= tot_frames || cnt > tot_frames - s) return 0;
    for (int unsigned i = 0; i < cnt; i++) begin
      if (!used_m[s + i]) begin
        used_m[s + i] = 1;
        free_cnt--;
      end
      rsv_m[s + i] = 1;
    end
    return 1;
  endfunction

  function automatic int unsigned count_allocatable();
    int unsigned lim, n;
    lim = ceiling();
    n = 0;
    if (lim == tot_frames) return free_cnt;
    for (int unsigned i = 0; i < lim; i++) if (!used_m[i]) n++;
    return n;
  endfunction

  function automatic frame_status_t run_cmd(logic [2:0] op, logic [47:0] addr,
                                            logic [15:0] cnt);
    frame_status_t r;
    int unsigned fr;
    bit good;
    good = 0;
    fr = 0;
    case (op)
      OP_ALLOC_ONE:   good = take_one(fr);
      OP_ALLOC_RUN:   good = take_run(cnt, fr);
      OP_ALLOC_ABOVE: good = take_above(addr, fr);
      OP_FREE_RUN: begin
        good = give_back(addr, cnt);
        if (!good && rej_cnt < 64'hFFFF_FFFF) rej_cnt++;
      end
      OP_RESERVE_RUN: good = pin_run(addr, cnt);
      default: good = 0;
    endcase
    r.raddr = '0;
    if (op <= OP_ALLOC_ABOVE) begin
      if (good) begin
        r.raddr = 24'(fr << 12);
        if (op == OP_ALLOC_RUN) grants.push_back('{fr, cnt});
        else grants.push_back('{fr, 1});
      end else if (fail_cnt < 64'hFFFF_FFFF) begin
        fail_cnt++;
      end
    end
    r.ok = good;
    r.nfree = 13'(free_cnt);
    r.nused = 13'(tot_frames - free_cnt);
    r.nalloc = 13'(count_allocatable());
    r.rejects = 32'(rej_cnt);
    r.fails = 32'(fail_cnt);
    r.scan = 13'(max_scan);
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        frame_status_t e;
        e = pending_q.pop_front();
        if (ok !== e.ok) begin
          $error("ok exp %0h got %0h", e.ok, ok); errors++;
        end
        if (result_address !== e.raddr) begin
          $error("result_address exp %0h got %0h", e.raddr, result_address); errors++;
        end
        if (free_frames !== e.nfree) begin
          $error("free_frames exp %0d got %0d", e.nfree, free_frames); errors++;
        end
        if (used_frames !== e.nused) begin
          $error("used_frames exp %0d got %0d", e.nused, used_frames); errors++;
        end
        if (allocatable_frames !== e.nalloc) begin
          $error("allocatable_frames exp %0d got %0d", e.nalloc, allocatable_frames);
          errors++;
        end
        if (rejected_free_total !== e.rejects) begin
          $error("rejected_free_total exp %0d got %0d", e.rejects, rejected_free_total);
          errors++;
        end
        if (failed_alloc_total !== e.fails) begin
          $error("failed_alloc_total exp %0d got %0d", e.fails, failed_alloc_total);
          errors++;
        end
        if (longest_scan !== e.scan) begin
          $error("longest_scan exp %0d got %0d", e.scan, longest_scan); errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || done) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_TOTAL) begin
      tot_frames = val[12:0];
      if (tot_frames < 1) tot_frames = 1;
      if (tot_frames > NF) tot_frames = NF;
      clear_maps();
    end else begin
      lim_reg = val[12:0];
    end
  endtask

  // drives one command and holds it until the transfer
  task automatic issue(logic [2:0] op, logic [47:0] addr, logic [15:0] cnt,
                       bit typed = 0, logic t_ok = 0, logic [23:0] t_addr = '0);
    frame_status_t e;
    start <= 1;
    operation <= op;
    address <= addr;
    frame_count <= cnt;
    do @(posedge clk); while (busy);
    e = run_cmd(op, addr, cnt);
    if (typed) begin
      e.ok = t_ok;
      e.raddr = t_addr;
    end
    pending_q.push_back(e);
  endtask

  task automatic drain();
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic random_cmd();
    int unsigned pick, lim, k;
    logic [47:0] a;
    logic [15:0] c;
    lim = ceiling();
    pick = $urandom_range(99);
    if (pick < 30) begin
      issue(OP_ALLOC_ONE, rand48(), 16'($urandom));
    end else if (pick < 45) begin
      case ($urandom_range(9))
        0: c = '0;
        1: c = 16'($urandom);
        2: c = 16'(lim + 1);
        default: c = 16'($urandom_range(8, 1));
      endcase
      issue(OP_ALLOC_RUN, rand48(), c);
    end else if (pick < 58) begin
      a = ($urandom_range(9) == 0) ? rand48()
          : 48'($urandom_range(lim * 4096));
      issue(OP_ALLOC_ABOVE, a, 16'($urandom));
    end else if (pick < 85) begin
      if (grants.size() != 0 && $urandom_range(9) < 7) begin
        k = $urandom_range(grants.size() - 1);
        issue(OP_FREE_RUN, 48'(grants[k].frame) << 12, 16'(grants[k].cnt));
        grants.delete(k);
      end else if ($urandom_range(1)) begin
        issue(OP_FREE_RUN, 48'($urandom_range(tot_frames - 1)) << 12,
              16'($urandom_range(3, 0)));
      end else begin
        issue(OP_FREE_RUN, rand48(), 16'($urandom));
      end
    end else if (pick < 96) begin
      if ($urandom_range(4) != 0)
        issue(OP_RESERVE_RUN, 48'($urandom_range(tot_frames - 1)) << 12,
              16'($urandom_range(4, 1)));
      else
        issue(OP_RESERVE_RUN, rand48(), 16'($urandom));
    end else begin
      issue(3'($urandom_range(7, 5)), rand48(), 16'($urandom));
    end
  endtask

  cmd_row_t rows[] = '{
    '{OP_ALLOC_ONE,   48'h0,            16'd0,     1, 1'b1, 24'h001000},
    '{OP_ALLOC_RUN,   48'h0,            16'd0,     1, 1'b0, 24'h0},
    '{OP_ALLOC_RUN,   48'h0,            16'hFFFF,  1, 1'b0, 24'h0},
    '{OP_ALLOC_RUN,   48'h0,            16'd2,     1, 1'b1, 24'h002000},
    '{OP_ALLOC_ABOVE, 48'h1001,         16'd0,     1, 1'b1, 24'h004000},
    '{OP_ALLOC_ABOVE, 48'hFFFFFFFFFFFF, 16'hFFFF,  1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h0,            16'd1,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h1001,         16'd1,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h1000,         16'd0,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h1000,         16'd1,     1, 1'b1, 24'h0},
    '{OP_FREE_RUN,    48'h1000,         16'd1,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'hFFF000,       16'd1,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h1000000,      16'd1,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h2000,         16'd4095,  1, 1'b0, 24'h0},
    '{OP_RESERVE_RUN, 48'h10000,        16'd8,     1, 1'b1, 24'h0},
    '{OP_RESERVE_RUN, 48'h10001,        16'd1,     1, 1'b0, 24'h0},
    '{OP_RESERVE_RUN, 48'h0,            16'd0,     1, 1'b0, 24'h0},
    '{OP_RESERVE_RUN, 48'hFFF000,       16'd2,     1, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h10000,        16'd1,     1, 1'b0, 24'h0},
    '{3'd5,           48'hFFFFFFFFFFFF, 16'hFFFF,  1, 1'b0, 24'h0},
    '{3'd7,           48'h0,            16'd0,     1, 1'b0, 24'h0},
    '{OP_ALLOC_RUN,   48'h0,            16'd1,     0, 1'b0, 24'h0},
    '{OP_FREE_RUN,    48'h2000,         16'd3,     1, 1'b1, 24'h0},
    '{OP_ALLOC_RUN,   48'h0,            16'd4,     0, 1'b0, 24'h0}
  };

  // {total_frames, alloc_limit_frames, items}; 8191 clamps to the full map
  int phase_cfg[8][3] = '{
    '{64, 64, 150}, '{16, 8, 130}, '{1, 0, 60}, '{200, 50, 150},
    '{8191, 100, 140}, '{96, 4096, 150}, '{32, 31, 150}, '{4096, 4096, 96}
  };

  initial begin
    int n, gap_pct;
    tot_frames = NF;
    lim_reg = NF;
    rej_cnt = 0;
    fail_cnt = 0;
    max_scan = 0;
    clear_maps();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i])
      issue(rows[i].op, rows[i].addr, rows[i].cnt, rows[i].typed, rows[i].ok,
            rows[i].raddr);
    drain();

    n = 0;
    foreach (phase_cfg[p]) begin
      reg_write(REG_TOTAL, phase_cfg[p][0]);
      reg_write(REG_LIMIT, phase_cfg[p][1]);
      for (int i = 0; i < phase_cfg[p][2]; i++) begin
        gap_pct = (n < 350) ? 23 : (n < 700) ? 73 : 0;
        if ($urandom_range(99) < gap_pct) begin
          start <= 0;
          repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        random_cmd();
        n++;
      end
      // whole pipeline empty before the next register update
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
